>>> sv/differential_drive_mixer_defines.svh
// assertion macros for the differential drive mixer checker
// no dependencies; included by files that carry assertions
`ifndef DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DDM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DDM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ddm_pkg.sv
// shared types, widths, constants and constant dividers for the drive mixer
// no dependencies
package ddm_pkg;

    localparam int IN_W        = 8;
    localparam int AX_W        = 7;
    localparam int GAIN_W      = 8;
    localparam int DZ_W        = 7;
    localparam int MI_W        = 10;
    localparam int KNEE_W      = 7;
    localparam int COEF_W      = 10;
    localparam int OUT_W       = 11;
    localparam int LEVEL_OUT_W = 16;
    localparam int REG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    localparam int LINEAR_TERM_COEF = 0;
    localparam int SHIFT_TERM       = 0;
    localparam int LTC100           = LINEAR_TERM_COEF * 100;
    localparam int SHIFT_LEVEL      = SHIFT_TERM / 100;

    localparam int PROD_W      = GAIN_W + AX_W;
    localparam int MIX_W       = PROD_W + 3;
    localparam int LIN_W       = COEF_W + AX_W;
    localparam int SQ_W        = 2 * AX_W;
    localparam int QUAD_W      = 25;
    localparam int QLVL_W      = 12;
    localparam int LINQ_W      = 11;
    localparam int SPQ_W       = 9;
    localparam int LVL_W       = 14;
    localparam int CMD_W       = 14;
    localparam int MAG_W       = CMD_W - 1;
    localparam int NUM_W       = MAG_W + MI_W;
    localparam int QUO_W       = MI_W;
    localparam int DIV_STAGES  = QUO_W;
    localparam int FRONT_STAGES = 6;

    localparam int DIV100_IN_W = 17;
    localparam int D100_MUL    = 167773;
    localparam int D100_MUL_W  = 18;
    localparam int D100_SH     = 24;
    localparam int D10K_MUL    = 54975582;
    localparam int D10K_MUL_W  = 26;
    localparam int D10K_SH     = 39;

    localparam logic [AX_W-1:0]  AX_MAX        = '1;
    localparam logic [OUT_W-1:0] OUT_MIN_CODE  = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_SHAPED = 1'b1
    } ddm_mode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_THR_PCT       = 3'd1,
        REG_STR_PCT       = 3'd2,
        REG_DEADBAND      = 3'd3,
        REG_CMD_LIMIT     = 3'd4,
        REG_QUAD_KNEE     = 3'd5,
        REG_LIN_COEF      = 3'd6,
        REG_QUAD_COEF     = 3'd7
    } ddm_reg_t;

    typedef struct packed {
        ddm_mode_t           mode;
        logic [GAIN_W-1:0]   thr_pct;
        logic [GAIN_W-1:0]   str_pct;
        logic [DZ_W-1:0]     deadband;
        logic [MI_W-1:0]     cmd_limit;
        logic [KNEE_W-1:0]   quad_knee;
        logic [COEF_W-1:0]   lin_coef;
        logic [COEF_W-1:0]   quad_coef;
    } ddm_cfg_t;

    localparam ddm_cfg_t CFG_RESET = '{
        mode:          MODE_LINEAR,
        thr_pct:       8'd100,
        str_pct:       8'd100,
        deadband:      7'd25,
        cmd_limit:     10'd928,
        quad_knee:     7'd64,
        lin_coef:      10'd100,
        quad_coef:     10'd0
    };

    typedef struct packed {
        logic            neg;
        logic [AX_W-1:0] mag;
    } ddm_axis_t;

    typedef struct packed {
        logic                           left_neg;
        logic                           right_neg;
        logic                           rescale;
        logic signed [OUT_W-1:0]        left_pass;
        logic signed [OUT_W-1:0]        right_pass;
        logic signed [LEVEL_OUT_W-1:0]  level;
    } ddm_side_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem_left;
        logic [NUM_W-1:0] rem_right;
        logic [MAG_W-1:0] divisor;
        logic [QUO_W-1:0] quo_left;
        logic [QUO_W-1:0] quo_right;
        ddm_side_t        side;
    } ddm_div_t;

    // floor(x / 100) by reciprocal, exact for any 17-bit x
    function automatic logic [DIV100_IN_W-1:0] div100(input logic [DIV100_IN_W-1:0] x);
        logic [DIV100_IN_W+D100_MUL_W-1:0] p;
        p = (DIV100_IN_W+D100_MUL_W)'(x) * (DIV100_IN_W+D100_MUL_W)'(D100_MUL);
        return DIV100_IN_W'(p >> D100_SH);
    endfunction

    // floor(x / 10000) by reciprocal, exact for any 25-bit x
    function automatic logic [QLVL_W-1:0] div10000(input logic [QUAD_W-1:0] x);
        logic [QUAD_W+D10K_MUL_W-1:0] p;
        p = (QUAD_W+D10K_MUL_W)'(x) * (QUAD_W+D10K_MUL_W)'(D10K_MUL);
        return QLVL_W'(p >> D10K_SH);
    endfunction

endpackage

>>> sv/ddm_front.sv
// front pipeline: axis conditioning, mixing, shaping and divider setup
// depends on ddm_pkg
module ddm_front import ddm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ddm_cfg_t               cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [IN_W-1:0] in_throttle,
    input  logic signed [IN_W-1:0] in_steering,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ddm_div_t               out_data
);

    function automatic ddm_axis_t axis_fix(input logic signed [IN_W-1:0] v,
                                           input logic [DZ_W-1:0] dz);
        logic [IN_W-1:0] raw;
        ddm_axis_t       a;
        raw   = v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
        a.neg = 1'b0;
        a.mag = '0;
        if (raw >= IN_W'(dz)) begin
            a.neg = v[IN_W-1];
            a.mag = raw[IN_W-1] ? AX_MAX : raw[AX_W-1:0];
        end
        return a;
    endfunction

    function automatic logic [AX_W-1:0] axis_shift(input ddm_axis_t a,
                                                   input logic [DZ_W-1:0] dz);
        return (a.mag == '0) ? '0 : a.mag - AX_W'(dz);
    endfunction

    // stage valids and load enables
    logic [FRONT_STAGES-1:0] valid_reg;
    logic [FRONT_STAGES-1:0] valid_in;
    logic [FRONT_STAGES-1:0] load;

    assign valid_in  = {valid_reg[FRONT_STAGES-2:0], in_valid};
    assign in_ready  = load[0];
    assign out_valid = valid_reg[FRONT_STAGES-1];

    always_comb begin
        load[FRONT_STAGES-1] = !valid_reg[FRONT_STAGES-1] || out_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < FRONT_STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    // stage 1: dead zone and shift toward zero
    ddm_axis_t       thr1_next, str1_next;
    logic [AX_W-1:0] t_sh1_next, s_sh1_next;
    ddm_axis_t       thr1_reg;
    logic            s_neg1_reg;
    logic [AX_W-1:0] t_sh1_reg, s_sh1_reg;

    always_comb begin
        thr1_next  = axis_fix(in_throttle, cfg.deadband);
        str1_next  = axis_fix(in_steering, cfg.deadband);
        t_sh1_next = axis_shift(thr1_next, cfg.deadband);
        s_sh1_next = axis_shift(str1_next, cfg.deadband);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            thr1_reg   <= thr1_next;
            s_neg1_reg <= str1_next.neg;
            t_sh1_reg  <= t_sh1_next;
            s_sh1_reg  <= s_sh1_next;
        end
    end

    // stage 2: gain products and knee split
    logic [PROD_W-1:0] tp2_next, sp2_next, tp2_reg, sp2_reg;
    logic [LIN_W-1:0]  lin2_next, lin2_reg;
    logic [AX_W-1:0]   q2_next, q2_reg;
    logic [SQ_W-1:0]   qsq2_next, qsq2_reg;
    logic              quad2_next, zero2_next;
    logic              quad2_reg, zero2_reg, t_neg2_reg, s_neg2_reg;

    always_comb begin
        tp2_next   = PROD_W'(cfg.thr_pct) * PROD_W'(t_sh1_reg);
        sp2_next   = PROD_W'(cfg.str_pct) * PROD_W'(s_sh1_reg);
        lin2_next  = LIN_W'(cfg.lin_coef) * LIN_W'(t_sh1_reg);
        quad2_next = thr1_reg.mag > cfg.quad_knee;
        zero2_next = thr1_reg.mag == '0;
        q2_next    = thr1_reg.mag - cfg.quad_knee;
        qsq2_next  = SQ_W'(q2_next) * SQ_W'(q2_next);
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            tp2_reg    <= tp2_next;
            sp2_reg    <= sp2_next;
            lin2_reg   <= lin2_next;
            q2_reg     <= q2_next;
            qsq2_reg   <= qsq2_next;
            quad2_reg  <= quad2_next;
            zero2_reg  <= zero2_next;
            t_neg2_reg <= thr1_reg.neg;
            s_neg2_reg <= s_neg1_reg;
        end
    end

    // stage 3: linear mix sums and quadratic numerator
    logic signed [MIX_W-1:0] tps, sps;
    logic signed [MIX_W-1:0] mixl3_next, mixr3_next, mixl3_reg, mixr3_reg;
    logic [QUAD_W-1:0]       quadp3_next, quadp3_reg;
    logic [LIN_W-1:0]        lin3_reg;
    logic [PROD_W-1:0]       sp3_reg;
    logic                    quad3_reg, zero3_reg, t_neg3_reg, s_neg3_reg;

    always_comb begin
        tps = signed'(MIX_W'(tp2_reg));
        sps = signed'(MIX_W'(sp2_reg));
        if (t_neg2_reg) begin
            tps = -tps;
        end
        if (s_neg2_reg) begin
            sps = -sps;
        end
        mixl3_next  = tps + sps;
        mixr3_next  = tps - sps;
        quadp3_next = QUAD_W'(cfg.quad_coef) * QUAD_W'(qsq2_reg)
                    + QUAD_W'(LTC100) * QUAD_W'(q2_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            mixl3_reg  <= mixl3_next;
            mixr3_reg  <= mixr3_next;
            quadp3_reg <= quadp3_next;
            lin3_reg   <= lin2_reg;
            sp3_reg    <= sp2_reg;
            quad3_reg  <= quad2_reg;
            zero3_reg  <= zero2_reg;
            t_neg3_reg <= t_neg2_reg;
            s_neg3_reg <= s_neg2_reg;
        end
    end

    // stage 4: divisions by constants, truncating toward zero
    logic signed [MIX_W-1:0] absl, absr;
    logic [MAG_W-1:0]        lq4_next, rq4_next, lq4_reg, rq4_reg;
    logic [LINQ_W-1:0]       linq4_next, linq4_reg;
    logic [SPQ_W-1:0]        spq4_next, spq4_reg;
    logic [QLVL_W-1:0]       quadq4_next, quadq4_reg;
    logic                    ln4_reg, rn4_reg, quad4_reg, zero4_reg, t_neg4_reg, s_neg4_reg;

    always_comb begin
        absl        = mixl3_reg[MIX_W-1] ? -mixl3_reg : mixl3_reg;
        absr        = mixr3_reg[MIX_W-1] ? -mixr3_reg : mixr3_reg;
        lq4_next    = MAG_W'(div100(DIV100_IN_W'(absl)));
        rq4_next    = MAG_W'(div100(DIV100_IN_W'(absr)));
        linq4_next  = LINQ_W'(div100(DIV100_IN_W'(lin3_reg)));
        spq4_next   = SPQ_W'(div100(DIV100_IN_W'(sp3_reg)));
        quadq4_next = div10000(quadp3_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            lq4_reg    <= lq4_next;
            rq4_reg    <= rq4_next;
            ln4_reg    <= mixl3_reg[MIX_W-1];
            rn4_reg    <= mixr3_reg[MIX_W-1];
            linq4_reg  <= linq4_next;
            spq4_reg   <= spq4_next;
            quadq4_reg <= quadq4_next;
            quad4_reg  <= quad3_reg;
            zero4_reg  <= zero3_reg;
            t_neg4_reg <= t_neg3_reg;
            s_neg4_reg <= s_neg3_reg;
        end
    end

    // stage 5: level select and final mix
    logic signed [LVL_W-1:0] lvl5_next, lvl5_reg;
    logic signed [CMD_W-1:0] slvl, spv;
    logic signed [CMD_W-1:0] left5_next, right5_next, left5_reg, right5_reg;

    always_comb begin
        lvl5_next = '0;
        if (cfg.mode == MODE_SHAPED && !zero4_reg) begin
            if (quad4_reg) begin
                lvl5_next = LVL_W'(quadq4_reg) + LVL_W'(SHIFT_LEVEL);
            end else begin
                lvl5_next = LVL_W'(linq4_reg);
            end
        end
        slvl = CMD_W'(lvl5_next);
        if (t_neg4_reg) begin
            slvl = -slvl;
        end
        spv = CMD_W'(spq4_reg);
        if (s_neg4_reg) begin
            spv = -spv;
        end
        if (cfg.mode == MODE_SHAPED) begin
            left5_next  = slvl + spv;
            right5_next = slvl - spv;
        end else begin
            left5_next  = ln4_reg ? -CMD_W'(lq4_reg) : CMD_W'(lq4_reg);
            right5_next = rn4_reg ? -CMD_W'(rq4_reg) : CMD_W'(rq4_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            lvl5_reg   <= lvl5_next;
            left5_reg  <= left5_next;
            right5_reg <= right5_next;
        end
    end

    // stage 6: magnitude, rescale decision, divider numerators
    logic signed [CMD_W-1:0] al, ar;
    logic [MAG_W-1:0]        lm, rm, big;
    ddm_div_t                div6_next, div6_reg;

    always_comb begin
        al  = left5_reg[CMD_W-1] ? -left5_reg : left5_reg;
        ar  = right5_reg[CMD_W-1] ? -right5_reg : right5_reg;
        lm  = MAG_W'(al);
        rm  = MAG_W'(ar);
        big = (lm > rm) ? lm : rm;
        div6_next.rem_left        = NUM_W'(lm) * NUM_W'(cfg.cmd_limit);
        div6_next.rem_right       = NUM_W'(rm) * NUM_W'(cfg.cmd_limit);
        div6_next.divisor         = big;
        div6_next.quo_left        = '0;
        div6_next.quo_right       = '0;
        div6_next.side.left_neg   = left5_reg[CMD_W-1];
        div6_next.side.right_neg  = right5_reg[CMD_W-1];
        div6_next.side.rescale    = big > MAG_W'(cfg.cmd_limit);
        div6_next.side.left_pass  = OUT_W'(left5_reg);
        div6_next.side.right_pass = OUT_W'(right5_reg);
        div6_next.side.level      = LEVEL_OUT_W'(lvl5_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[5]) begin
            div6_reg <= div6_next;
        end
    end

    assign out_data = div6_reg;

endmodule

>>> sv/ddm_cell.sv
// one restoring division cell: one quotient bit for each of the two commands
// depends on ddm_pkg
module ddm_cell import ddm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  ddm_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output ddm_div_t out_data
);

    logic             valid_reg;
    ddm_div_t         data_reg, data_next;
    logic [NUM_W-1:0] dsh;
    logic             take_l, take_r;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next = in_data;
        dsh       = NUM_W'({in_data.divisor, {(QUO_W-1){1'b0}}});
        take_l    = in_data.rem_left >= dsh;
        take_r    = in_data.rem_right >= dsh;
        data_next.rem_left  = (take_l ? in_data.rem_left - dsh : in_data.rem_left) << 1;
        data_next.rem_right = (take_r ? in_data.rem_right - dsh : in_data.rem_right) << 1;
        data_next.quo_left  = {in_data.quo_left[QUO_W-2:0], take_l};
        data_next.quo_right = {in_data.quo_right[QUO_W-2:0], take_r};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> sv/differential_drive_mixer.sv
// differential drive mixer top: config registers, front pipeline, divider cell row
// depends on ddm_pkg, ddm_front, ddm_cell
// path: an accepted request is registered in turn through the
// 6 front stages, one divider cell per quotient bit (10), then 1 output register
// throughput: one request per cycle when the result side keeps up
// reset: synchronous, clears all valids and loads the register defaults
module differential_drive_mixer import ddm_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [REG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [IN_W-1:0]        s_throttle,
    input  logic signed [IN_W-1:0]        s_steering,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_W-1:0]       m_left_cmd,
    output logic signed [OUT_W-1:0]       m_right_cmd,
    output logic signed [LEVEL_OUT_W-1:0] m_throttle_level
);

    ddm_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (ddm_reg_t'(cfg_index))
                REG_MODE:          cfg_reg.mode          <= ddm_mode_t'(cfg_data[0]);
                REG_THR_PCT:       cfg_reg.thr_pct       <= cfg_data[GAIN_W-1:0];
                REG_STR_PCT:       cfg_reg.str_pct       <= cfg_data[GAIN_W-1:0];
                REG_DEADBAND:      cfg_reg.deadband      <= cfg_data[DZ_W-1:0];
                REG_CMD_LIMIT:     cfg_reg.cmd_limit     <= cfg_data[MI_W-1:0];
                REG_QUAD_KNEE:     cfg_reg.quad_knee     <= cfg_data[KNEE_W-1:0];
                REG_LIN_COEF:      cfg_reg.lin_coef      <= cfg_data[COEF_W-1:0];
                REG_QUAD_COEF:     cfg_reg.quad_coef     <= cfg_data[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ddm_div_t                chain_data [0:DIV_STAGES];
    logic [DIV_STAGES:0]     chain_valid;
    logic [DIV_STAGES:0]     chain_ready;

    ddm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_throttle (s_throttle),
        .in_steering (s_steering),
        .out_valid   (chain_valid[0]),
        .out_ready   (chain_ready[0]),
        .out_data    (chain_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_cell
        ddm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // output register
    logic                          out_valid_reg;
    logic                          out_load;
    ddm_div_t                      last;
    logic signed [OUT_W-1:0]       left_next, right_next, left_reg, right_reg;
    logic signed [OUT_W-1:0]       ql, qr;
    logic signed [LEVEL_OUT_W-1:0] level_reg;

    assign out_load                = !out_valid_reg || m_ready;
    assign chain_ready[DIV_STAGES] = out_load;
    assign last                    = chain_data[DIV_STAGES];

    always_comb begin
        ql = OUT_W'(last.quo_left);
        qr = OUT_W'(last.quo_right);
        if (last.side.left_neg) begin
            ql = -ql;
        end
        if (last.side.right_neg) begin
            qr = -qr;
        end
        left_next  = last.side.rescale ? ql : last.side.left_pass;
        right_next = last.side.rescale ? qr : last.side.right_pass;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= chain_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            level_reg <= last.side.level;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_left_cmd       = left_reg;
    assign m_right_cmd      = right_reg;
    assign m_throttle_level = level_reg;

endmodule

>>> sv/ddm_checker.sv
// port-level checks for the differential drive mixer, bound to the top level
// depends on ddm_pkg and differential_drive_mixer_defines.svh
`include "differential_drive_mixer_defines.svh"

module ddm_checker import ddm_pkg::*; (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [REG_IDX_W-1:0]          cfg_index,
    input logic [CFG_DATA_W-1:0]         cfg_data,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [IN_W-1:0]        s_throttle,
    input logic signed [IN_W-1:0]        s_steering,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [OUT_W-1:0]       m_left_cmd,
    input logic signed [OUT_W-1:0]       m_right_cmd,
    input logic signed [LEVEL_OUT_W-1:0] m_throttle_level
);

    // config writes are never refused
    `DDM_ASSERT_NOW(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready, "config request refused")

    // input only stalls when the whole pipe is full behind a waiting result
    `DDM_ASSERT_NOW(a_stall_source, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without a waiting result")

    // left and right commands stay within the symmetric range
    `DDM_ASSERT_NOW(a_cmd_range, aclk, aresetn, m_valid, (m_left_cmd != OUT_MIN_CODE) && (m_right_cmd != OUT_MIN_CODE), "motor command out of range")

    `DDM_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_left_cmd) && $stable(m_right_cmd) && $stable(m_throttle_level), "stalled result changed")

endmodule

bind differential_drive_mixer ddm_checker u_ddm_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for differential_drive_mixer: stick requests, register writes, checks
// depends on ddm_pkg and the differential_drive_mixer rtl; needs no files or arguments
module testbench;
    import ddm_pkg::*;

    localparam int RUN_LIMIT    = 800000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_ITEMS  = 90;

    typedef struct {
        logic signed [OUT_W-1:0]       left_cmd;
        logic signed [OUT_W-1:0]       right_cmd;
        logic signed [LEVEL_OUT_W-1:0] throttle_level;
    } drive_cmd_t;

    class mix_scoreboard;
        ddm_cfg_t   cfg;
        drive_cmd_t pending_cmds[$];
        int         errors;
        int         checked;
        int         requests;

        function new();
            cfg      = CFG_RESET;
            errors   = 0;
            checked  = 0;
            requests = 0;
        endfunction

        function void write_reg(ddm_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:          cfg.mode = ddm_mode_t'(data[0]);
                REG_THR_PCT:       cfg.thr_pct = data[GAIN_W-1:0];
                REG_STR_PCT:       cfg.str_pct = data[GAIN_W-1:0];
                REG_DEADBAND:      cfg.deadband = data[DZ_W-1:0];
                REG_CMD_LIMIT:     cfg.cmd_limit = data[MI_W-1:0];
                REG_QUAD_KNEE:     cfg.quad_knee = data[KNEE_W-1:0];
                REG_LIN_COEF:      cfg.lin_coef = data[COEF_W-1:0];
                REG_QUAD_COEF:     cfg.quad_coef = data[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        // zero inside the dead zone, fold -128 onto -127
        function longint axis_clean(logic signed [IN_W-1:0] raw);
            longint v;
            longint dz;
            v  = longint'(raw);
            dz = longint'(cfg.deadband);
            if ((v < 0 ? -v : v) < dz) v = 0;
            if (v == -128) v = -127;
            return v;
        endfunction

        // pull a nonzero axis toward zero by the dead zone
        function longint axis_pull(longint v);
            longint dz;
            dz = longint'(cfg.deadband);
            if (v > 0) return v - dz;
            if (v < 0) return v + dz;
            return 0;
        endfunction

        function drive_cmd_t mix_sticks(logic signed [IN_W-1:0] thr_in,
                                        logic signed [IN_W-1:0] str_in);
            drive_cmd_t res;
            longint thr, str, tp, sp, left, right, big, level, sgn, m, q;
            longint tg, sg, dz, mi, knee, lc, qc;
            tg    = longint'(cfg.thr_pct);
            sg    = longint'(cfg.str_pct);
            dz    = longint'(cfg.deadband);
            mi    = longint'(cfg.cmd_limit);
            knee  = longint'(cfg.quad_knee);
            lc    = longint'(cfg.lin_coef);
            qc    = longint'(cfg.quad_coef);
            thr   = axis_clean(thr_in);
            str   = axis_pull(axis_clean(str_in));
            level = 0;
            if (cfg.mode == MODE_LINEAR) begin
                tp    = tg * axis_pull(thr);
                sp    = sg * str;
                left  = (tp + sp) / 100;
                right = (tp - sp) / 100;
            end else begin
                sgn = thr < 0 ? -1 : 1;
                m   = thr < 0 ? -thr : thr;
                if (m != 0) begin
                    if (m <= knee) begin
                        level = (lc * (m - dz)) / 100;
                    end else begin
                        q     = m - knee;
                        level = ((qc * (q * q)) / 100 + longint'(LINEAR_TERM_COEF) * q) / 100
                                + longint'(SHIFT_TERM) / 100;
                    end
                end
                sp    = (sg * str) / 100;
                left  = sgn * level + sp;
                right = sgn * level - sp;
            end
            big = (left < 0 ? -left : left);
            if ((right < 0 ? -right : right) > big) big = (right < 0 ? -right : right);
            if (big > mi) begin
                left  = (left * mi) / big;
                right = (right * mi) / big;
            end
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            res.left_cmd       = left[OUT_W-1:0];
            res.right_cmd      = right[OUT_W-1:0];
            res.throttle_level = level[LEVEL_OUT_W-1:0];
            return res;
        endfunction

        function void note_request(logic signed [IN_W-1:0] thr, logic signed [IN_W-1:0] str);
            pending_cmds.push_back(mix_sticks(thr, str));
            requests++;
        endfunction

        function void check_result(logic signed [OUT_W-1:0] left,
                                   logic signed [OUT_W-1:0] right,
                                   logic signed [LEVEL_OUT_W-1:0] level);
            drive_cmd_t exp_cmd;
            if (pending_cmds.size() == 0) begin
                $error("result with no request outstanding: left %0d right %0d level %0d",
                       left, right, level);
                errors++;
                return;
            end
            exp_cmd = pending_cmds.pop_front();
            checked++;
            if (left !== exp_cmd.left_cmd) begin
                $error("left_cmd mismatch: expected %0d, actual %0d", exp_cmd.left_cmd, left);
                errors++;
            end
            if (right !== exp_cmd.right_cmd) begin
                $error("right_cmd mismatch: expected %0d, actual %0d", exp_cmd.right_cmd, right);
                errors++;
            end
            if (level !== exp_cmd.throttle_level) begin
                $error("throttle_level mismatch: expected %0d, actual %0d",
                       exp_cmd.throttle_level, level);
                errors++;
            end
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [REG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [IN_W-1:0]        s_throttle = '0;
    logic signed [IN_W-1:0]        s_steering = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [OUT_W-1:0]       m_left_cmd;
    logic signed [OUT_W-1:0]       m_right_cmd;
    logic signed [LEVEL_OUT_W-1:0] m_throttle_level;

    mix_scoreboard sb = new();
    int  cycle_count = 0;
    int  stall_left = 0;
    int  settings_used = 1;
    bit  calm = 1'b0;

    differential_drive_mixer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_throttle       (s_throttle),
        .s_steering       (s_steering),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_cmd       (m_left_cmd),
        .m_right_cmd      (m_right_cmd),
        .m_throttle_level (m_throttle_level)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn || calm) begin
            m_ready = aresetn;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_left_cmd, m_right_cmd, m_throttle_level);
    end

    task automatic send_stick(logic signed [IN_W-1:0] thr, logic signed [IN_W-1:0] str);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_throttle = thr;
        s_steering = str;
        s_valid    = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_request(thr, str);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(ddm_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // all eight registers, unused upper data bits filled with junk
    task automatic apply_setting(ddm_cfg_t c);
        ddm_reg_t              idx;
        logic [CFG_DATA_W-1:0] val;
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        s_valid = 1'b0;
        drain_results();
        for (int i = 0; i < 8; i++) begin
            idx  = ddm_reg_t'(i);
            junk = CFG_DATA_W'($urandom);
            case (idx)
                REG_MODE:          begin val = CFG_DATA_W'(c.mode);          mask = 10'h001; end
                REG_THR_PCT:       begin val = CFG_DATA_W'(c.thr_pct);       mask = 10'h0ff; end
                REG_STR_PCT:       begin val = CFG_DATA_W'(c.str_pct);       mask = 10'h0ff; end
                REG_DEADBAND:      begin val = CFG_DATA_W'(c.deadband);      mask = 10'h07f; end
                REG_CMD_LIMIT:     begin val = CFG_DATA_W'(c.cmd_limit);     mask = 10'h3ff; end
                REG_QUAD_KNEE:     begin val = CFG_DATA_W'(c.quad_knee);     mask = 10'h07f; end
                REG_LIN_COEF:      begin val = CFG_DATA_W'(c.lin_coef);      mask = 10'h3ff; end
                default:           begin val = CFG_DATA_W'(c.quad_coef);     mask = 10'h3ff; end
            endcase
            write_reg(idx, (val & mask) | (junk & ~mask));
        end
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    function automatic ddm_cfg_t pick_setting(int kind);
        ddm_cfg_t c;
        case (kind)
            0: c = '{mode: MODE_LINEAR, thr_pct: 8'd0, str_pct: 8'd0, deadband: 7'd0,
                     cmd_limit: 10'd0, quad_knee: 7'd0, lin_coef: 10'd0, quad_coef: 10'd0};
            1: c = '{mode: MODE_SHAPED, thr_pct: 8'hff, str_pct: 8'hff,
                     deadband: 7'h7f, cmd_limit: 10'h3ff, quad_knee: 7'h7f,
                     lin_coef: 10'h3ff, quad_coef: 10'h3ff};
            2: c = '{mode: MODE_SHAPED, thr_pct: 8'hff, str_pct: 8'hff,
                     deadband: 7'd0, cmd_limit: 10'h3ff, quad_knee: 7'd0,
                     lin_coef: 10'h3ff, quad_coef: 10'h3ff};
            default: begin
                c.mode      = ddm_mode_t'($urandom_range(0, 1));
                c.thr_pct   = GAIN_W'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 250));
                c.str_pct   = GAIN_W'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 250));
                c.deadband  = DZ_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                                : $urandom_range(0, 40));
                c.cmd_limit = MI_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                                : $urandom_range(1, 1023));
                c.quad_knee = KNEE_W'($urandom_range(0, 127));
                c.lin_coef  = COEF_W'(($urandom_range(0, 9) == 0) ? 1023
                                                                  : $urandom_range(0, 1000));
                c.quad_coef = COEF_W'(($urandom_range(0, 9) == 0) ? 1023
                                                                  : $urandom_range(0, 1000));
            end
        endcase
        return c;
    endfunction

    // stick values biased toward the dead zone edge, the knee and the end stops
    function automatic logic signed [IN_W-1:0] pick_axis(int dz, int knee);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 2))
                0: v = -128;
                1: v = -127;
                default: v = 127;
            endcase
        end else if (r < 45) begin
            v = (r < 30 ? dz : knee) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1)) v = -v;
        end else begin
            v = int'($urandom_range(0, 255)) - 128;
        end
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return v[IN_W-1:0];
    endfunction

    initial begin
        int dir_thr[12] = '{127, -128, -128, 127, 0, 24, 25, -25, 1, 64, 65, -100};
        int dir_str[12] = '{127, -128, 127, -128, 0, -24, 25, -26, -1, 0, -65, 50};
        ddm_cfg_t shaped_cfg;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        calm = 1'b1;
        for (int i = 0; i < 12; i++) send_stick(dir_thr[i][IN_W-1:0], dir_str[i][IN_W-1:0]);
        calm = 1'b0;
        shaped_cfg = '{mode: MODE_SHAPED, thr_pct: 8'd250, str_pct: 8'd250,
                       deadband: 7'd10, cmd_limit: 10'd100, quad_knee: 7'd40,
                       lin_coef: 10'd1000, quad_coef: 10'd1000};
        apply_setting(shaped_cfg);
        for (int i = 0; i < 12; i++) send_stick(dir_thr[i][IN_W-1:0], dir_str[i][IN_W-1:0]);

        for (int p = 0; p < RAND_PHASES; p++) begin
            apply_setting(pick_setting(p));
            calm = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_stick(pick_axis(int'(sb.cfg.deadband), int'(sb.cfg.quad_knee)),
                           pick_axis(int'(sb.cfg.deadband), int'(sb.cfg.quad_knee)));
        end
        s_valid = 1'b0;
        calm = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d stick requests under %0d register settings, both mixing modes",
                 sb.requests, settings_used);
        $display("%0d results compared field by field, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/ddm_pkg.sv
sv/ddm_front.sv
sv/ddm_cell.sv
sv/differential_drive_mixer.sv
sv/ddm_checker.sv
tb/sv/testbench.sv
